[hw/rtl/assert_macros.svh]
// Assertion macros used by the Q-table update engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled while rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/qtu_pkg.sv]
// Shared types and fixed constants of the Q-table update engine.
`timescale 1ns / 1ps

package qtu_pkg;

    // Q values: signed, 24 bits
    localparam int Q_W   = 24;
    localparam int Q_MAX = 8388607;
    localparam int Q_MIN = -8388608;

    // Rates carry 12 fraction bits, 4096 is 1.0
    localparam int RATE_FRAC = 12;
    localparam int RATE_ONE  = 4096;
    localparam int RATE_W    = 13;
    localparam int THR_W     = 17;

    // Word field widths
    localparam int STATE_IN_W = 12;
    localparam int ACT_IN_W   = 2;
    localparam int REWARD_W   = 4;
    localparam int DRAW_W     = 16;

    // Configuration port
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    localparam logic [RATE_W-1:0] LR_RESET    = 13'd410;
    localparam logic [RATE_W-1:0] GAMMA_RESET = 13'd3686;
    localparam logic [THR_W-1:0]  THR_RESET   = 17'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_RATE         = 2'd0,
        CFG_FUTURE_WEIGHT     = 2'd1,
        CFG_EXPLORE_THRESHOLD = 2'd2
    } cfg_index_t;

    // Stage enables from the sequencer to the update datapath
    typedef struct packed {
        logic load_en;
        logic mul1_en;
        logic tgt_en;
        logic mul2_en;
        logic acc_en;
    } dp_ctrl_t;

endpackage

[hw/rtl/qtu_q_store.sv]
// Q store: one row of action values per state, two registered reads, one write.
`timescale 1ns / 1ps

module qtu_q_store #(
    parameter int ROWS  = 4096,
    parameter int ROW_W = 96,
    localparam int ADDR_W = $clog2(ROWS)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [ROW_W-1:0]  rd_data_a,
    output logic [ROW_W-1:0]  rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data
);

    logic [ROW_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[hw/rtl/qtu_row_max.sv]
// First maximum of one row of Q values.
`timescale 1ns / 1ps

module qtu_row_max #(
    parameter int ACTION_COUNT = 4,
    localparam int IDX_W = $clog2(ACTION_COUNT)
) (
    input  logic [ACTION_COUNT*qtu_pkg::Q_W-1:0] row,
    output logic [IDX_W-1:0]                     best_idx,
    output logic signed [qtu_pkg::Q_W-1:0]       best_val
);

    // Strict compare keeps the lowest index among equal maxima
    always_comb
    begin
        best_idx = '0;
        best_val = $signed(row[qtu_pkg::Q_W-1:0]);
        for (int i = 1; i < ACTION_COUNT; i++)
        begin
            if ($signed(row[i*qtu_pkg::Q_W +: qtu_pkg::Q_W]) > best_val)
            begin
                best_val = $signed(row[i*qtu_pkg::Q_W +: qtu_pkg::Q_W]);
                best_idx = IDX_W'(i);
            end
        end
    end

endmodule

[hw/rtl/qtu_update_dp.sv]
// Fixed-point Q update: target, weighted blend, floor shift and saturation.
`timescale 1ns / 1ps

module qtu_update_dp #(
    parameter int Q_FRAC_BITS = 12
) (
    input  logic                                 clk,
    input  qtu_pkg::dp_ctrl_t                    ctrl,
    input  logic [qtu_pkg::RATE_W-1:0]           step_rate,
    input  logic [qtu_pkg::RATE_W-1:0]           future_weight,
    input  logic signed [qtu_pkg::REWARD_W-1:0]  reward,
    input  logic signed [qtu_pkg::Q_W-1:0]       cur_q,
    input  logic signed [qtu_pkg::Q_W-1:0]       max_q,
    output logic signed [qtu_pkg::Q_W-1:0]       new_q
);

    localparam int RW    = qtu_pkg::RATE_W + 1;
    localparam int GP_W  = RW + qtu_pkg::Q_W;
    localparam int GS_W  = GP_W - qtu_pkg::RATE_FRAC;
    localparam int RS_W  = qtu_pkg::REWARD_W + Q_FRAC_BITS;
    localparam int TGT_W = ((GS_W > RS_W) ? GS_W : RS_W) + 1;
    localparam int OP_W  = RW + qtu_pkg::Q_W;
    localparam int NP_W  = RW + TGT_W;
    localparam int ACC_W = ((OP_W > NP_W) ? OP_W : NP_W) + 1;
    localparam int SH_W  = ACC_W - qtu_pkg::RATE_FRAC;

    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(qtu_pkg::Q_MAX);
    localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(qtu_pkg::Q_MIN);

    logic signed [qtu_pkg::Q_W-1:0] cur_reg;
    logic signed [qtu_pkg::Q_W-1:0] max_reg;
    logic signed [GP_W-1:0]         gprod_reg;
    logic signed [OP_W-1:0]         oprod_reg;
    logic signed [TGT_W-1:0]        tgt_reg;
    logic signed [NP_W-1:0]         nprod_reg;
    logic signed [qtu_pkg::Q_W-1:0] new_q_reg;

    logic signed [RW-1:0]           gamma_s;
    logic signed [RW-1:0]           lr_s;
    logic signed [RW-1:0]           wold_s;
    logic signed [GP_W-1:0]         gprod_next;
    logic signed [OP_W-1:0]         oprod_next;
    logic signed [GS_W-1:0]         gshift;
    logic signed [RS_W-1:0]         rscaled;
    logic signed [TGT_W-1:0]        tgt_next;
    logic signed [NP_W-1:0]         nprod_next;
    logic signed [ACC_W-1:0]        acc;
    logic signed [SH_W-1:0]         acc_sh;
    logic signed [qtu_pkg::Q_W-1:0] new_q_next;

    assign gamma_s = $signed({1'b0, future_weight});
    assign lr_s    = $signed({1'b0, step_rate});
    // Weight on the old value goes negative when the rate exceeds one
    assign wold_s  = RW'(qtu_pkg::RATE_ONE) - lr_s;

    assign gprod_next = gamma_s * max_reg;
    assign oprod_next = wold_s * cur_reg;

    // Arithmetic shift is a floor shift
    assign gshift   = $signed(gprod_reg[GP_W-1:qtu_pkg::RATE_FRAC]);
    assign rscaled  = {reward, {Q_FRAC_BITS{1'b0}}};
    assign tgt_next = TGT_W'(rscaled) + TGT_W'(gshift);

    assign nprod_next = lr_s * tgt_reg;

    assign acc    = ACC_W'(oprod_reg) + ACC_W'(nprod_reg);
    assign acc_sh = $signed(acc[ACC_W-1:qtu_pkg::RATE_FRAC]);

    always_comb
    begin
        if (acc_sh > SAT_HI)
        begin
            new_q_next = qtu_pkg::Q_W'(SAT_HI);
        end
        else if (acc_sh < SAT_LO)
        begin
            new_q_next = qtu_pkg::Q_W'(SAT_LO);
        end
        else
        begin
            new_q_next = acc_sh[qtu_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            cur_reg <= cur_q;
            max_reg <= max_q;
        end
        if (ctrl.mul1_en)
        begin
            gprod_reg <= gprod_next;
            oprod_reg <= oprod_next;
        end
        if (ctrl.tgt_en)
        begin
            tgt_reg <= tgt_next;
        end
        if (ctrl.mul2_en)
        begin
            nprod_reg <= nprod_next;
        end
        if (ctrl.acc_en)
        begin
            new_q_reg <= new_q_next;
        end
    end

    assign new_q = new_q_reg;

endmodule

[hw/rtl/q_table_update_engine_top.sv]
// Top level of the Q-table update engine: sequencer, index wrap, store and outputs.
`timescale 1ns / 1ps

// Tabular Q-learning update engine. Pulse start with a word on the input ports
// while busy is low; the word is taken at that edge. done rises for exactly one
// cycle with next_action, explored and new_q, and the receiver cannot hold it
// off, so capture it on that cycle. busy drops on the same cycle as done, so a
// new word is taken only once the last one is through; the sequencer walks one
// word at a time through state-index wrap, the registered read of the Q memory,
// two multiply stages and the write-back of the updated row. After reset a
// clearing pass zeroes the Q memory one row per cycle, with busy held high.
// Configuration writes (learning rate, discount factor, explore threshold) are
// taken on any edge with cfg_wr_en high; issue them only while the engine is idle.
// The target max uses the row of next_state before the write-back; the greedy
// pick uses it after, which matters when next_state equals current_state.

`include "assert_macros.svh"

module q_table_update_engine_top #(
    parameter int STATE_COUNT  = 4096,
    parameter int ACTION_COUNT = 4,
    parameter int Q_FRAC_BITS  = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [qtu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [qtu_pkg::CFG_DATA_W-1:0]        cfg_data,
    // command
    input  logic                                  start,
    output logic                                  busy,
    input  logic [qtu_pkg::STATE_IN_W-1:0]        current_state,
    input  logic [qtu_pkg::ACT_IN_W-1:0]          action,
    input  logic signed [qtu_pkg::REWARD_W-1:0]   reward,
    input  logic [qtu_pkg::STATE_IN_W-1:0]        next_state,
    input  logic [qtu_pkg::DRAW_W-1:0]            random_draw,
    input  logic [qtu_pkg::ACT_IN_W-1:0]          random_action,
    // result
    output logic                                  done,
    output logic [qtu_pkg::ACT_IN_W-1:0]          next_action,
    output logic                                  explored,
    output logic signed [qtu_pkg::Q_W-1:0]        new_q
);

    localparam int SI_W   = $clog2(STATE_COUNT);
    localparam int AI_W   = $clog2(ACTION_COUNT);
    localparam int AX_W   = AI_W + 1;
    localparam int ACT_W  = qtu_pkg::ACT_IN_W;
    localparam int SIN_W  = qtu_pkg::STATE_IN_W;
    localparam int HALF   = SIN_W / 2;
    localparam int QW     = qtu_pkg::Q_W;
    localparam int ROW_W  = ACTION_COUNT * QW;
    localparam longint SPAN = longint'(1) << SIN_W;
    localparam logic [SI_W-1:0] CLR_LAST = SI_W'(STATE_COUNT - 1);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'h001,
        ST_CLEAR   = 11'h002,
        ST_WRAP_HI = 11'h004,
        ST_WRAP_LO = 11'h008,
        ST_READ    = 11'h010,
        ST_LOAD    = 11'h020,
        ST_MUL1    = 11'h040,
        ST_TGT     = 11'h080,
        ST_MUL2    = 11'h100,
        ST_ACC     = 11'h200,
        ST_WRITE   = 11'h400
    } state_t;

    state_t state_reg, state_next;
    logic [SI_W-1:0] clr_cnt_reg;

    // configuration registers
    logic [qtu_pkg::RATE_W-1:0] lr_reg;
    logic [qtu_pkg::RATE_W-1:0] gamma_reg;
    logic [qtu_pkg::THR_W-1:0]  thr_reg;

    // word held for the whole update
    logic [SIN_W-1:0]                   s_red_reg;
    logic [SIN_W-1:0]                   sn_red_reg;
    logic [AI_W-1:0]                    a_reg;
    logic [AI_W-1:0]                    ra_reg;
    logic signed [qtu_pkg::REWARD_W-1:0] reward_reg;
    logic                               explore_reg;

    // result word
    logic                       done_reg;
    logic [ACT_W-1:0]           next_action_reg;
    logic                       explored_reg;
    logic signed [QW-1:0]       new_q_out_reg;

    logic                       accept;
    logic [SIN_W-1:0]           s_hi, sn_hi, s_lo, sn_lo;
    logic [AX_W-1:0]            a_wrap, ra_wrap;
    logic [SI_W-1:0]            s_idx, sn_idx;

    logic                       mem_rd_en;
    logic                       mem_wr_en;
    logic [SI_W-1:0]            mem_wr_addr;
    logic [ROW_W-1:0]           mem_wr_data;
    logic [ROW_W-1:0]           rd_row_a, rd_row_b;
    logic [ROW_W-1:0]           wr_row, upd_row;

    logic signed [QW-1:0]       cur_q;
    logic signed [QW-1:0]       max_q;
    logic [AI_W-1:0]            target_idx;
    logic [AI_W-1:0]            greedy_idx;
    logic signed [QW-1:0]       greedy_val;
    logic signed [QW-1:0]       dp_new_q;
    qtu_pkg::dp_ctrl_t          dp_ctrl;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WRAP_HI;
                end
            end
            ST_WRAP_HI: state_next = ST_WRAP_LO;
            ST_WRAP_LO: state_next = ST_READ;
            ST_READ:    state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_TGT;
            ST_TGT:     state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_ACC;
            ST_ACC:     state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= (state_reg == ST_WRITE);
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers: written whenever enabled, unknown indexes dropped
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= qtu_pkg::LR_RESET;
            gamma_reg <= qtu_pkg::GAMMA_RESET;
            thr_reg   <= qtu_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                qtu_pkg::CFG_STEP_RATE:
                    lr_reg <= cfg_data[qtu_pkg::RATE_W-1:0];
                qtu_pkg::CFG_FUTURE_WEIGHT:
                    gamma_reg <= cfg_data[qtu_pkg::RATE_W-1:0];
                qtu_pkg::CFG_EXPLORE_THRESHOLD:
                    thr_reg <= cfg_data[qtu_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Index wrap. Actions need at most one subtract of ACTION_COUNT.
    // State indexes reduce by shifted subtracts, upper half of the shifts
    // in ST_WRAP_HI, lower half in ST_WRAP_LO after it.
    // ---------------------------------------------------------------
    always_comb
    begin
        a_wrap  = AX_W'(action);
        ra_wrap = AX_W'(random_action);
        if (a_wrap >= AX_W'(ACTION_COUNT))
        begin
            a_wrap = a_wrap - AX_W'(ACTION_COUNT);
        end
        if (ra_wrap >= AX_W'(ACTION_COUNT))
        begin
            ra_wrap = ra_wrap - AX_W'(ACTION_COUNT);
        end
    end

    always_comb
    begin
        longint step;
        s_hi  = s_red_reg;
        sn_hi = sn_red_reg;
        for (int i = SIN_W - 1; i >= HALF; i--)
        begin
            step = longint'(STATE_COUNT) << i;
            if (step < SPAN)
            begin
                if (longint'(s_hi) >= step)
                begin
                    s_hi = s_hi - SIN_W'(step);
                end
                if (longint'(sn_hi) >= step)
                begin
                    sn_hi = sn_hi - SIN_W'(step);
                end
            end
        end
    end

    always_comb
    begin
        longint step;
        s_lo  = s_red_reg;
        sn_lo = sn_red_reg;
        for (int i = HALF - 1; i >= 0; i--)
        begin
            step = longint'(STATE_COUNT) << i;
            if (step < SPAN)
            begin
                if (longint'(s_lo) >= step)
                begin
                    s_lo = s_lo - SIN_W'(step);
                end
                if (longint'(sn_lo) >= step)
                begin
                    sn_lo = sn_lo - SIN_W'(step);
                end
            end
        end
    end

    assign s_idx  = SI_W'(s_red_reg);
    assign sn_idx = SI_W'(sn_red_reg);

    // Hold the word; indexes are reduced in place
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_red_reg   <= current_state;
            sn_red_reg  <= next_state;
            a_reg       <= AI_W'(a_wrap);
            ra_reg      <= AI_W'(ra_wrap);
            reward_reg  <= reward;
            explore_reg <= ({1'b0, random_draw} < thr_reg);
        end
        else if (state_reg == ST_WRAP_HI)
        begin
            s_red_reg  <= s_hi;
            sn_red_reg <= sn_hi;
        end
        else if (state_reg == ST_WRAP_LO)
        begin
            s_red_reg  <= s_lo;
            sn_red_reg <= sn_lo;
        end
    end

    // ---------------------------------------------------------------
    // Q memory: clear every row after reset, read both rows, write back the current row once
    // ---------------------------------------------------------------
    assign mem_rd_en = (state_reg == ST_READ);

    always_comb
    begin
        wr_row = rd_row_a;
        wr_row[a_reg*QW +: QW] = dp_new_q;
        // greedy pick sees the row after the write-back
        upd_row = rd_row_b;
        if (s_idx == sn_idx)
        begin
            upd_row[a_reg*QW +: QW] = dp_new_q;
        end
    end

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = s_idx;
        mem_wr_data = wr_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_data = '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_wr_en = 1'b1;
        end
    end

    qtu_q_store #(
        .ROWS  (STATE_COUNT),
        .ROW_W (ROW_W)
    ) u_store (
        .clk       (clk),
        .rd_en     (mem_rd_en),
        .rd_addr_a (s_idx),
        .rd_addr_b (sn_idx),
        .rd_data_a (rd_row_a),
        .rd_data_b (rd_row_b),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data)
    );

    // ---------------------------------------------------------------
    // Row maxima: target uses the row as read, greedy the updated row
    // ---------------------------------------------------------------
    assign cur_q = $signed(rd_row_a[a_reg*QW +: QW]);

    qtu_row_max #(
        .ACTION_COUNT (ACTION_COUNT)
    ) u_max_target (
        .row      (rd_row_b),
        .best_idx (target_idx),
        .best_val (max_q)
    );

    qtu_row_max #(
        .ACTION_COUNT (ACTION_COUNT)
    ) u_max_greedy (
        .row      (upd_row),
        .best_idx (greedy_idx),
        .best_val (greedy_val)
    );

    // ---------------------------------------------------------------
    // Update arithmetic
    // ---------------------------------------------------------------
    assign dp_ctrl.load_en = (state_reg == ST_LOAD);
    assign dp_ctrl.mul1_en = (state_reg == ST_MUL1);
    assign dp_ctrl.tgt_en  = (state_reg == ST_TGT);
    assign dp_ctrl.mul2_en = (state_reg == ST_MUL2);
    assign dp_ctrl.acc_en  = (state_reg == ST_ACC);

    qtu_update_dp #(
        .Q_FRAC_BITS (Q_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .ctrl          (dp_ctrl),
        .step_rate     (lr_reg),
        .future_weight (gamma_reg),
        .reward        (reward_reg),
        .cur_q         (cur_q),
        .max_q         (max_q),
        .new_q         (dp_new_q)
    );

    // ---------------------------------------------------------------
    // Result word, registered on the write-back cycle
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            next_action_reg <= explore_reg ? ACT_W'(ra_reg) : ACT_W'(greedy_idx);
            explored_reg    <= explore_reg;
            new_q_out_reg   <= dp_new_q;
        end
    end

    assign done        = done_reg;
    assign next_action = next_action_reg;
    assign explored    = explored_reg;
    assign new_q       = new_q_out_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_NEXT(a_write_gives_done, state_reg == ST_WRITE, done_reg, "write-back without done strobe")
    `ASSERT_IMPLIES(a_done_from_write, done_reg, $past(state_reg == ST_WRITE), "done strobe without write-back")
    `ASSERT_NEXT(a_clear_ends, (state_reg == ST_CLEAR) && (clr_cnt_reg == CLR_LAST), state_reg == ST_IDLE, "clearing pass did not end on the last row")
    `ASSERT_IMPLIES(a_explore_action, done_reg && explored_reg, next_action == ACT_W'(ra_reg), "explored word lost the random action")
    `ASSERT_IMPLIES(a_rows_apart, (state_reg == ST_WRITE) && (s_idx != sn_idx), (greedy_idx == target_idx) && (greedy_val == max_q), "untouched next row gave two different maxima")

endmodule

[sim/q_table_update_engine_top_tb.sv]
// Self-checking testbench for the Q-table update engine: directed table, then random phases.
`timescale 1ns / 1ps

module q_table_update_engine_top_tb;

    localparam int STATE_COUNT  = 4096;
    localparam int ACTION_COUNT = 4;
    localparam int Q_FRAC_BITS  = 12;
    localparam int ENTRY_COUNT  = STATE_COUNT * ACTION_COUNT;

    // The clearing pass after reset accepts nothing while it runs; the limit leaves
    // room for it before declaring the engine stuck.
    localparam int STALL_LIMIT      = 4 * STATE_COUNT;
    localparam int DIRECTED_WORDS   = 20;
    localparam int SETTING_COUNT    = 6;
    localparam int WORDS_PER_PHASE  = 150;
    localparam int POOL_SIZE        = 8;
    // Random words in this window go in back to back, with no idle cycles
    localparam int QUIET_FROM       = 380;
    localparam int QUIET_TO         = 530;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct packed {
        logic [qtu_pkg::STATE_IN_W-1:0]      current_state;
        logic [qtu_pkg::ACT_IN_W-1:0]        action;
        logic signed [qtu_pkg::REWARD_W-1:0] reward;
        logic [qtu_pkg::STATE_IN_W-1:0]      next_state;
        logic [qtu_pkg::DRAW_W-1:0]          random_draw;
        logic [qtu_pkg::ACT_IN_W-1:0]        random_action;
    } step_word_t;

    localparam int WORD_W = $bits(step_word_t);

    typedef struct packed {
        logic [qtu_pkg::ACT_IN_W-1:0]   next_action;
        logic                           explored;
        logic signed [qtu_pkg::Q_W-1:0] new_q;
    } outcome_t;

    typedef struct packed {
        step_word_t word;
        logic       typed;
        outcome_t   want;
    } directed_row_t;

    typedef struct packed {
        logic [qtu_pkg::RATE_W-1:0] lr;
        logic [qtu_pkg::RATE_W-1:0] gamma;
        logic [qtu_pkg::THR_W-1:0]  thr;
    } setting_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    qtu_pkg::cfg_index_t                 cfg_index = qtu_pkg::CFG_STEP_RATE;
    logic [qtu_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [qtu_pkg::STATE_IN_W-1:0]      current_state = '0;
    logic [qtu_pkg::ACT_IN_W-1:0]        action = '0;
    logic signed [qtu_pkg::REWARD_W-1:0] reward = '0;
    logic [qtu_pkg::STATE_IN_W-1:0]      next_state = '0;
    logic [qtu_pkg::DRAW_W-1:0]          random_draw = '0;
    logic [qtu_pkg::ACT_IN_W-1:0]        random_action = '0;
    logic                                done;
    logic [qtu_pkg::ACT_IN_W-1:0]        next_action;
    logic                                explored;
    logic signed [qtu_pkg::Q_W-1:0]      new_q;

    // Shadow of the Q store and of the three registers
    logic signed [qtu_pkg::Q_W-1:0] q_shadow [ENTRY_COUNT];
    logic [qtu_pkg::RATE_W-1:0]     lr_cfg    = qtu_pkg::LR_RESET;
    logic [qtu_pkg::RATE_W-1:0]     gamma_cfg = qtu_pkg::GAMMA_RESET;
    logic [qtu_pkg::THR_W-1:0]      thr_cfg   = qtu_pkg::THR_RESET;

    outcome_t pending_outcomes [$];
    logic [qtu_pkg::STATE_IN_W-1:0] state_pool [POOL_SIZE];

    int error_count     = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int random_sent     = 0;
    int explore_seen    = 0;
    int saturated_seen  = 0;
    int stall_cycles    = 0;

    // Directed words, all taken with the reset settings on a freshly cleared store.
    // Only the rows whose outcome is obvious carry a typed expectation.
    directed_row_t directed_rows [DIRECTED_WORDS] = '{
        // empty store, reward zero: value stays zero, tie resolves to action 0
        '{'{0, 0, 0, 0, 65535, 3}, 1'b1, '{0, 1'b0, 0}},
        // draw of zero is below the threshold: take the supplied action
        '{'{0, 0, 0, 0, 0, 3}, 1'b1, '{3, 1'b1, 0}},
        // draw equal to the threshold stays greedy; same state, lowest reward
        '{'{4095, 3, -8, 4095, 6554, 0}, 1'b0, '0},
        // one below the threshold explores; top reward
        '{'{4095, 3, 7, 4095, 6553, 2}, 1'b0, '0},
        // same state: greedy pick must see the value just written
        '{'{1, 2, 7, 1, 65535, 1}, 1'b0, '0},
        '{'{1, 1, 7, 1, 65535, 0}, 1'b0, '0},
        '{'{2, 0, 5, 1, 40000, 3}, 1'b0, '0},
        '{'{2, 3, 5, 2, 65535, 3}, 1'b0, '0},
        // small negative rewards exercise the round-down of the shifts
        '{'{3, 1, -1, 3, 65535, 0}, 1'b0, '0},
        '{'{3, 1, -1, 3, 65535, 0}, 1'b0, '0},
        // alternating bit patterns on every field
        '{'{12'hAAA, 1, -6, 12'h555, 16'hAAAA, 1}, 1'b0, '0},
        '{'{12'h555, 2, 5, 12'hAAA, 16'h5555, 2}, 1'b0, '0},
        // build an exact tie between actions 1 and 3 of state 6
        '{'{6, 1, 2, 100, 65535, 0}, 1'b0, '0},
        '{'{6, 3, 2, 100, 65535, 0}, 1'b0, '0},
        '{'{7, 0, 0, 6, 65535, 0}, 1'b0, '0},
        // make state 8 negative on three actions
        '{'{8, 0, -8, 9, 65535, 0}, 1'b0, '0},
        '{'{8, 1, -8, 9, 65535, 0}, 1'b0, '0},
        '{'{8, 2, -8, 9, 65535, 0}, 1'b0, '0},
        // only action 3 of state 8 is still zero, so greedy takes it
        '{'{9, 0, 0, 8, 65535, 2}, 1'b1, '{3, 1'b0, 0}},
        '{'{5, 2, 0, 5, 0, 0}, 1'b1, '{0, 1'b1, 0}}
    };

    q_table_update_engine_top #(
        .STATE_COUNT  (STATE_COUNT),
        .ACTION_COUNT (ACTION_COUNT),
        .Q_FRAC_BITS  (Q_FRAC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .current_state (current_state),
        .action        (action),
        .reward        (reward),
        .next_state    (next_state),
        .random_draw   (random_draw),
        .random_action (random_action),
        .done          (done),
        .next_action   (next_action),
        .explored      (explored),
        .new_q         (new_q)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // First action holding the maximum of a row of the shadow store
    function automatic logic [qtu_pkg::ACT_IN_W-1:0] greedy_action(
        input logic [qtu_pkg::STATE_IN_W-1:0] st);
        int base;
        int best;
        base = int'(st) * ACTION_COUNT;
        best = 0;
        for (int a = 1; a < ACTION_COUNT; a++)
        begin
            if (q_shadow[base + a] > q_shadow[base + best])
                best = a;
        end
        return qtu_pkg::ACT_IN_W'(best);
    endfunction

    // Apply one Q-learning update to the shadow store and return what the engine
    // should report for it
    function automatic outcome_t q_learn_step(input step_word_t w);
        outcome_t o;
        int       cur_idx;
        longint   cur;
        longint   maxq;
        longint   target;
        longint   acc;
        cur_idx = int'(w.current_state) * ACTION_COUNT + int'(w.action);
        cur     = longint'(q_shadow[cur_idx]);
        // target max is taken over the row before the write-back
        maxq    = longint'(q_shadow[int'(w.next_state) * ACTION_COUNT
                                    + int'(greedy_action(w.next_state))]);
        target  = longint'($signed(w.reward)) * (longint'(1) <<< Q_FRAC_BITS)
                + ((longint'(gamma_cfg) * maxq) >>> qtu_pkg::RATE_FRAC);
        acc     = (longint'(qtu_pkg::RATE_ONE) - longint'(lr_cfg)) * cur
                + longint'(lr_cfg) * target;
        acc     = acc >>> qtu_pkg::RATE_FRAC;
        if (acc > longint'(qtu_pkg::Q_MAX))
            acc = longint'(qtu_pkg::Q_MAX);
        if (acc < longint'(qtu_pkg::Q_MIN))
            acc = longint'(qtu_pkg::Q_MIN);
        q_shadow[cur_idx] = acc[qtu_pkg::Q_W-1:0];
        o.new_q    = acc[qtu_pkg::Q_W-1:0];
        o.explored = (qtu_pkg::THR_W'(w.random_draw) < thr_cfg);
        // greedy pick looks at the row after the write-back
        o.next_action = o.explored ? w.random_action : greedy_action(w.next_state);
        return o;
    endfunction

    // Present one word, hold start until the engine takes it, and log what the
    // engine owes for it. Enter and leave on a rising edge.
    task automatic send_word(input step_word_t w, input logic typed, input outcome_t want,
                             input bit may_idle);
        int       gap;
        outcome_t predicted;
        gap = 0;
        if (may_idle && $urandom_range(0, 99) < 28)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        current_state <= w.current_state;
        action        <= w.action;
        reward        <= w.reward;
        next_state    <= w.next_state;
        random_draw   <= w.random_draw;
        random_action <= w.random_action;
        // busy read here is the value the engine saw at this edge
        do
            @(posedge clk);
        while (busy);
        predicted = q_learn_step(w);
        pending_outcomes.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // Drop start and wait for every owed result and for the engine to go idle
    task automatic drain;
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; engine must be idle
    task automatic write_settings(input setting_t cfg);
        cfg_wr_en <= 1'b1;
        cfg_index <= qtu_pkg::CFG_STEP_RATE;
        cfg_data  <= qtu_pkg::CFG_DATA_W'(cfg.lr);
        @(posedge clk);
        cfg_index <= qtu_pkg::CFG_FUTURE_WEIGHT;
        cfg_data  <= qtu_pkg::CFG_DATA_W'(cfg.gamma);
        @(posedge clk);
        cfg_index <= qtu_pkg::CFG_EXPLORE_THRESHOLD;
        cfg_data  <= cfg.thr;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lr_cfg    = cfg.lr;
        gamma_cfg = cfg.gamma;
        thr_cfg   = cfg.thr;
    endtask

    // Mostly transitions among a handful of states so the rows build up real
    // values, often with the next state equal to the current one; the rest noise.
    function automatic step_word_t random_word();
        step_word_t w;
        int         near;
        w = step_word_t'(WORD_W'({$urandom, $urandom}));
        if ($urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 99) < 85)
                w.current_state = state_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 99) < 30)
                w.next_state = w.current_state;
            else if ($urandom_range(0, 99) < 85)
                w.next_state = state_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        // hit the threshold edge now and then
        if (thr_cfg != 0 && $urandom_range(0, 4) == 0)
        begin
            near = int'(thr_cfg) - $urandom_range(0, 1);
            if (near > 65535)
                near = 65535;
            w.random_draw = qtu_pkg::DRAW_W'(near);
        end
        return w;
    endfunction

    function automatic setting_t phase_setting(input int phase);
        case (phase)
            // full step, discount above 1.0: values run into saturation, never explore
            0: return '{13'd4096, 13'd8191, 17'd0};
            // weight on the old value goes negative; every draw explores
            1: return '{13'd8191, 13'd0, 17'd131071};
            // nothing learnt; only the top draw stays greedy
            2: return '{13'd0, 13'd4096, 17'd65535};
            3: return '{13'd1, 13'd1, 17'd65536};
            4: return '{qtu_pkg::RATE_W'($urandom_range(0, 8191)),
                        qtu_pkg::RATE_W'($urandom_range(0, 8191)),
                        qtu_pkg::THR_W'($urandom_range(0, 131071))};
            default: return '{qtu_pkg::LR_RESET, qtu_pkg::GAMMA_RESET, qtu_pkg::THR_RESET};
        endcase
    endfunction

    // Result side: the engine cannot be held off, so take every strobe as it comes
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with nothing owed: next_action %0d explored %0d new_q %0d",
                       next_action, explored, new_q);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (explored)
                    explore_seen++;
                if (new_q == qtu_pkg::Q_W'(qtu_pkg::Q_MAX)
                    || new_q == qtu_pkg::Q_W'(qtu_pkg::Q_MIN))
                    saturated_seen++;
                if (next_action !== want.next_action)
                begin
                    $error("next_action: expected %0d, got %0d", want.next_action, next_action);
                    error_count++;
                end
                if (explored !== want.explored)
                begin
                    $error("explored: expected %0d, got %0d", want.explored, explored);
                    error_count++;
                end
                if (new_q !== want.new_q)
                begin
                    $error("new_q: expected %0d, got %0d", want.new_q, new_q);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted word or result restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: nothing accepted for %0d cycles, %0d results owed",
                         stall_cycles, pending_outcomes.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < ENTRY_COUNT; i++)
            q_shadow[i] = '0;

        // Hold reset low, then release on an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs on the reset settings; send_word waits out the
        // clearing pass through busy
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want,
                      1'b1);
        drain();

        for (int phase = 0; phase < SETTING_COUNT; phase++)
        begin
            write_settings(phase_setting(phase));
            for (int k = 0; k < POOL_SIZE; k++)
                state_pool[k] = qtu_pkg::STATE_IN_W'($urandom_range(0, STATE_COUNT - 1));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                send_word(random_word(), 1'b0, '0,
                          !(random_sent >= QUIET_FROM && random_sent < QUIET_TO));
                random_sent++;
            end
            drain();
        end

        // Let any stray strobe show up before closing
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d directed, %0d random) over %0d register settings.",
                 words_sent, DIRECTED_WORDS, random_sent, SETTING_COUNT);
        $display("Checked %0d results: %0d explored, %0d at a saturation limit.",
                 results_checked, explore_seen, saturated_seen);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
